// ----- rtl/hbawc_pkg.sv -----
// shared types and constants of the h-bridge arm window controller
// command, mode, status, fault and register codes, sequencer states
// no dependencies
package hbawc_pkg;

	// command codes carried in s_tuser
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_ARM   = 3'd1;
	localparam logic [2:0] CMD_OFF   = 3'd2;
	localparam logic [2:0] CMD_CHAN  = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;

	// drive modes, also the in2/in1 pin pair of a channel
	localparam logic [1:0] MODE_COAST   = 2'd0;
	localparam logic [1:0] MODE_FORWARD = 2'd1;
	localparam logic [1:0] MODE_REVERSE = 2'd2;
	localparam logic [1:0] MODE_BRAKE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_CHAN  = 3'd1;
	localparam logic [2:0] ST_NOT_ARMED = 3'd2;
	localparam logic [2:0] ST_DUTY_OVER = 3'd3;
	localparam logic [2:0] ST_ZERO_DUR  = 3'd4;

	// fault mask bits
	localparam logic [2:0] FLT_TIMEOUT   = 3'b001;
	localparam logic [2:0] FLT_NOT_ARMED = 3'b010;
	localparam logic [2:0] FLT_DUTY      = 3'b100;

	// configuration register indexes
	localparam logic [2:0] REG_DUTY_LIMIT   = 3'd0;
	localparam logic [2:0] REG_CMD_TIMEOUT  = 3'd1;
	localparam logic [2:0] REG_ARM_MAX      = 3'd2;
	localparam logic [2:0] REG_WAKE_DELAY   = 3'd3;
	localparam logic [2:0] REG_SLEEP_POLAR  = 3'd4;

	// register reset values
	localparam logic [9:0]  DUTY_LIMIT_RST        = 10'd500;
	localparam logic [15:0] CMD_TIMEOUT_RST       = 16'd2000;
	localparam logic [23:0] ARM_MAX_RST           = 24'd60000;
	localparam logic [7:0]  WAKE_DELAY_RST        = 8'd1;
	localparam logic        SLEEP_ACTIVE_HIGH_RST = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_INC    = 9'b000000010,
		S_ARMCHK = 9'b000000100,
		S_CHSCAN = 9'b000001000,
		S_CHECK  = 9'b000010000,
		S_CLAMP  = 9'b000100000,
		S_ADD1   = 9'b001000000,
		S_ADD2   = 9'b010000000,
		S_REMAIN = 9'b100000000
	} state_t;

endpackage

// ----- rtl/hbridge_arm_window_controller.sv -----
// top level of the h-bridge arm window controller: sequencer, shared adder,
// channel stores, configuration registers and output register
// depends on hbawc_pkg
//
// One command beat is taken at a time and answered with one result beat.
// A query, off or rejected command goes to the result register; a channel
// command gets an arm check if armed and driving, a limit check and, if
// passed, a clamp and an add; an arm a clamp and two adds; a tick a time
// step, a window check if armed and a channel scan. All use the single
// 32-bit add/subtract unit, which advances the time count, compares each
// deadline, clamps durations, forms deadlines and works out the remaining
// arm time, one use per cycle. s_tready is high only in the idle state; a
// result waits in the output register while the next command is taken.
module hbridge_arm_window_controller #(
	parameter int CHANNEL_COUNT = 3
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// configuration write port
	input  logic                                         cfg_we,
	input  logic [2:0]                                   cfg_addr,
	input  logic [23:0]                                  cfg_wdata,
	// command stream
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// tuser: cmd[2:0]
	input  logic [2:0]                                   s_tuser,
	// tdata: channel[1:0], drive_mode[3:2], duty[13:4], duration[45:14], pad
	input  logic [47:0]                                  s_tdata,
	// result stream
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// tdata: status, fault_mask, bridge_pins (2 per channel), sleep_pin, armed,
	// arm_remaining_ms, chan_mode, chan_duty, chan_deadline, zero pad
	output logic [((84 + 2*CHANNEL_COUNT + 7) / 8) * 8 - 1:0] m_tdata
);
	import hbawc_pkg::*;

	localparam int PIN_W   = 2 * CHANNEL_COUNT;
	localparam int OUT_W   = 84 + PIN_W;
	localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNEL_COUNT - 1);

	// configuration
	logic [9:0]  duty_limit_q;
	logic [15:0] cmd_timeout_q;
	logic [23:0] arm_max_q;
	logic [7:0]  wake_delay_q;
	logic        sleep_high_q;

	// block state
	state_t      state_q;
	logic [31:0] now_q;
	logic        arm_active_q;
	logic [31:0] arm_deadline_q;
	logic [1:0]  mode_st_q [CHANNEL_COUNT];
	logic [9:0]  duty_st_q [CHANNEL_COUNT];
	logic [31:0] dl_st_q   [CHANNEL_COUNT];
	logic [PIN_W-1:0] pins_q;

	// current command
	logic [2:0]  cmd_q;
	logic [1:0]  ch_q;
	logic [1:0]  mode_q;
	logic [9:0]  duty_q;
	logic [31:0] dur_q;
	logic [31:0] acc_q;
	logic [2:0]  status_q;
	logic [2:0]  faults_q;
	logic [CH_W-1:0] idx_q;

	logic               out_valid_q;
	logic [TDATA_W-1:0] out_q;

	// input fields
	logic [2:0]  in_cmd;
	logic [1:0]  in_ch;
	logic [1:0]  in_mode;
	logic [9:0]  in_duty;
	logic [31:0] in_dur;
	logic [1:0]  mode_eff;
	logic        in_ch_ok;
	logic        s_fire;

	// shared add/subtract unit
	logic [31:0] unit_a;
	logic [31:0] unit_b;
	logic        unit_sub;
	logic [32:0] unit_sum;
	logic        reached;
	logic        a_lt_b;

	logic            cmd_ch_ok;
	logic [CH_W-1:0] sel;
	logic            sel_ok;
	logic            off_now;
	logic            out_free;
	logic            out_load;
	logic            report;
	logic [31:0]     remaining;
	logic [OUT_W-1:0] out_d;

	assign in_cmd  = s_tuser;
	assign in_ch   = s_tdata[1:0];
	assign in_mode = s_tdata[3:2];
	assign in_duty = s_tdata[13:4];
	assign in_dur  = s_tdata[45:14];

	// zero duty means coast unless braking
	assign mode_eff = (in_duty == 10'd0 && in_mode != MODE_BRAKE) ? MODE_COAST : in_mode;
	assign in_ch_ok  = 32'(in_ch) < 32'(CHANNEL_COUNT);
	assign cmd_ch_ok = 32'(ch_q) < 32'(CHANNEL_COUNT);

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	// one store read port: scan index while scanning, else the command's channel
	assign sel    = (state_q == S_CHSCAN) ? idx_q : CH_W'(ch_q);
	assign sel_ok = (state_q == S_CHSCAN) || cmd_ch_ok;

	always_comb begin
		unit_a   = arm_deadline_q;
		unit_b   = now_q;
		unit_sub = 1'b1;
		unique case (state_q)
			S_INC: begin
				unit_a   = now_q;
				unit_b   = 32'd1;
				unit_sub = 1'b0;
			end
			S_ARMCHK: begin
				unit_a = now_q;
				unit_b = arm_deadline_q;
			end
			S_CHSCAN: begin
				unit_a = now_q;
				unit_b = dl_st_q[sel];
			end
			S_CLAMP: begin
				unit_a = (cmd_q == CMD_ARM) ? 32'(arm_max_q) : 32'(cmd_timeout_q);
				unit_b = dur_q;
			end
			S_ADD1: begin
				unit_a   = now_q;
				unit_b   = dur_q;
				unit_sub = 1'b0;
			end
			S_ADD2: begin
				unit_a   = acc_q;
				unit_b   = 32'(wake_delay_q);
				unit_sub = 1'b0;
			end
			default: begin
				unit_a   = arm_deadline_q;
				unit_b   = now_q;
				unit_sub = 1'b1;
			end
		endcase
	end

	assign unit_sum = {1'b0, unit_a} + {1'b0, unit_sub ? ~unit_b : unit_b} + 33'(unit_sub);
	// deadline reached when the wrapped difference is non-negative
	assign reached  = ~unit_sum[31];
	// borrow out of the subtract
	assign a_lt_b   = ~unit_sum[32];

	always_comb begin
		off_now = 1'b0;
		unique case (state_q)
			S_IDLE:   off_now = s_fire && (in_cmd == CMD_OFF);
			S_ARMCHK: off_now = reached;
			S_CHECK:  off_now = (mode_q != MODE_COAST && !arm_active_q)
			                    || (duty_q > duty_limit_q);
			default:  off_now = 1'b0;
		endcase
	end

	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == S_REMAIN) && out_free;
	assign report    = (cmd_q == CMD_CHAN || cmd_q == CMD_QUERY) && cmd_ch_ok;
	assign remaining = arm_active_q ? unit_sum[31:0] : 32'd0;

	always_comb begin
		out_d = '0;
		out_d[2:0]          = status_q;
		out_d[5:3]          = faults_q;
		out_d[6 +: PIN_W]   = pins_q;
		out_d[6 + PIN_W]    = arm_active_q ^ ~sleep_high_q;
		out_d[7 + PIN_W]    = arm_active_q;
		out_d[8 + PIN_W +: 32] = remaining;
		if (report) begin
			out_d[40 + PIN_W +: 2]  = mode_st_q[sel];
			out_d[42 + PIN_W +: 10] = duty_st_q[sel];
			out_d[52 + PIN_W +: 32] = dl_st_q[sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q   <= DUTY_LIMIT_RST;
			cmd_timeout_q  <= CMD_TIMEOUT_RST;
			arm_max_q      <= ARM_MAX_RST;
			wake_delay_q   <= WAKE_DELAY_RST;
			sleep_high_q   <= SLEEP_ACTIVE_HIGH_RST;
			state_q        <= S_IDLE;
			now_q          <= '0;
			arm_active_q   <= 1'b0;
			arm_deadline_q <= '0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				mode_st_q[i] <= MODE_COAST;
				duty_st_q[i] <= '0;
				dl_st_q[i]   <= '0;
			end
			pins_q      <= '0;
			cmd_q       <= CMD_TICK;
			ch_q        <= '0;
			mode_q      <= MODE_COAST;
			duty_q      <= '0;
			dur_q       <= '0;
			acc_q       <= '0;
			status_q    <= ST_OK;
			faults_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DUTY_LIMIT:  duty_limit_q  <= cfg_wdata[9:0];
					REG_CMD_TIMEOUT: cmd_timeout_q <= cfg_wdata[15:0];
					REG_ARM_MAX:     arm_max_q     <= cfg_wdata[23:0];
					REG_WAKE_DELAY:  wake_delay_q  <= cfg_wdata[7:0];
					REG_SLEEP_POLAR: sleep_high_q  <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (m_tready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						cmd_q    <= in_cmd;
						ch_q     <= in_ch;
						mode_q   <= mode_eff;
						duty_q   <= in_duty;
						dur_q    <= in_dur;
						status_q <= ST_OK;
						faults_q <= '0;
						idx_q    <= '0;
						priority case (in_cmd)
							CMD_TICK: state_q <= S_INC;
							CMD_ARM:  state_q <= S_CLAMP;
							CMD_CHAN: begin
								if (!in_ch_ok) begin
									status_q <= ST_BAD_CHAN;
									state_q  <= S_REMAIN;
								end else if (mode_eff != MODE_COAST && arm_active_q) begin
									state_q <= S_ARMCHK;
								end else begin
									state_q <= S_CHECK;
								end
							end
							CMD_QUERY: begin
								if (!in_ch_ok)
									status_q <= ST_BAD_CHAN;
								state_q <= S_REMAIN;
							end
							default: state_q <= S_REMAIN;
						endcase
					end
				end
				S_INC: begin
					now_q   <= unit_sum[31:0];
					state_q <= arm_active_q ? S_ARMCHK : S_CHSCAN;
				end
				S_ARMCHK: begin
					if (reached) begin
						// window expired: timeout, and a command then sees not armed
						if (cmd_q == CMD_CHAN) begin
							faults_q <= FLT_TIMEOUT | FLT_NOT_ARMED;
							status_q <= ST_NOT_ARMED;
						end else begin
							faults_q <= FLT_TIMEOUT;
						end
						state_q <= S_REMAIN;
					end else begin
						state_q <= (cmd_q == CMD_CHAN) ? S_CHECK : S_CHSCAN;
					end
				end
				S_CHSCAN: begin
					if (mode_st_q[sel] != MODE_COAST && reached) begin
						mode_st_q[sel]      <= MODE_COAST;
						duty_st_q[sel]      <= '0;
						dl_st_q[sel]        <= '0;
						pins_q[2*sel +: 2]  <= MODE_COAST;
					end
					if (idx_q == LAST_CH)
						state_q <= S_REMAIN;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_CHECK: begin
					priority if (mode_q != MODE_COAST && !arm_active_q) begin
						faults_q <= faults_q | FLT_NOT_ARMED;
						status_q <= ST_NOT_ARMED;
						state_q  <= S_REMAIN;
					end else if (duty_q > duty_limit_q) begin
						faults_q <= faults_q | FLT_DUTY;
						status_q <= ST_DUTY_OVER;
						state_q  <= S_REMAIN;
					end else if (mode_q != MODE_COAST && dur_q == 32'd0) begin
						pins_q[2*sel +: 2] <= MODE_COAST;
						status_q <= ST_ZERO_DUR;
						state_q  <= S_REMAIN;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (a_lt_b)
						dur_q <= unit_a;
					state_q <= S_ADD1;
				end
				S_ADD1: begin
					acc_q <= unit_sum[31:0];
					if (cmd_q == CMD_ARM) begin
						state_q <= S_ADD2;
					end else begin
						if (sel_ok) begin
							mode_st_q[sel] <= mode_q;
							duty_st_q[sel] <= duty_q;
							dl_st_q[sel]   <= (mode_q == MODE_COAST) ? 32'd0 : unit_sum[31:0];
							pins_q[2*sel +: 2] <= mode_q;
						end
						state_q <= S_REMAIN;
					end
				end
				S_ADD2: begin
					arm_deadline_q <= unit_sum[31:0];
					arm_active_q   <= 1'b1;
					for (int i = 0; i < CHANNEL_COUNT; i++) begin
						mode_st_q[i] <= MODE_COAST;
						duty_st_q[i] <= '0;
						dl_st_q[i]   <= '0;
					end
					pins_q  <= '0;
					state_q <= S_REMAIN;
				end
				S_REMAIN: begin
					if (out_free) begin
						out_q       <= TDATA_W'(out_d);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// off: disarm and coast every channel, overrides the step's own writes
			if (off_now) begin
				arm_active_q   <= 1'b0;
				arm_deadline_q <= '0;
				for (int i = 0; i < CHANNEL_COUNT; i++) begin
					mode_st_q[i] <= MODE_COAST;
					duty_st_q[i] <= '0;
					dl_st_q[i]   <= '0;
				end
				pins_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ----- rtl/hbawc_checker.sv -----
// port-level checks of the h-bridge arm window controller, bound to the top level
// depends on hbawc_pkg and hbridge_arm_window_controller
module hbawc_checker #(
	parameter int CHANNEL_COUNT = 3
) (
	input logic                                         clk,
	input logic                                         arst_n,
	input logic                                         s_tvalid,
	input logic                                         s_tready,
	input logic                                         m_tvalid,
	input logic                                         m_tready,
	input logic [((84 + 2*CHANNEL_COUNT + 7) / 8) * 8 - 1:0] m_tdata
);
	import hbawc_pkg::*;

	localparam int PIN_W = 2 * CHANNEL_COUNT;

	logic [2:0]       st;
	logic [2:0]       flt;
	logic [PIN_W-1:0] pins;
	logic             armed;
	logic [31:0]      rem;
	logic [43:0]      chan_fields;

	assign st          = m_tdata[2:0];
	assign flt         = m_tdata[5:3];
	assign pins        = m_tdata[6 +: PIN_W];
	assign armed       = m_tdata[7 + PIN_W];
	assign rem         = m_tdata[8 + PIN_W +: 32];
	assign chan_fields = m_tdata[40 + PIN_W +: 44];

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one command at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while previous one still in work");

	// disarmed results show no remaining window
	a_disarmed_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !armed |-> rem == 32'd0)
		else $error("remaining arm time while disarmed");

	// any fault leaves the bridge off and disarmed
	a_fault_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flt != 3'd0 |-> !armed && pins == '0)
		else $error("fault without shutdown");

	// a rejected channel reports no fault and no channel fields
	a_bad_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_BAD_CHAN |-> flt == 3'd0 && chan_fields == '0)
		else $error("bad channel result carries channel data");

endmodule

bind hbridge_arm_window_controller hbawc_checker #(
	.CHANNEL_COUNT(CHANNEL_COUNT)
) u_hbawc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
